// ===== hw/rtl/codebook_background_model_macros.svh =====
// ----------------------------------------------------------------------------
// Codebook background model assertion macros
// Shared assertion forms for the codebook background model RTL.
// ----------------------------------------------------------------------------
`ifndef CODEBOOK_BACKGROUND_MODEL_MACROS_SVH
`define CODEBOOK_BACKGROUND_MODEL_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CBM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Codebook background model package
// Beat types, operation codes and register indexes.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam logic [1:0] OP_LEARN    = 2'd0;
   localparam logic [1:0] OP_CLEAR    = 2'd1;
   localparam logic [1:0] OP_CLASSIFY = 2'd2;

   localparam logic [1:0] REG_LEARN_BOUNDS = 2'd0;
   localparam logic [1:0] REG_MIN_MODS     = 2'd1;
   localparam logic [1:0] REG_MAX_MODS     = 2'd2;

   localparam int SAT_MAX = 255;

   typedef struct packed {
      logic [1:0] operation;
      logic [9:0] pixel_index;
      logic [7:0] chan_zero;
      logic [7:0] chan_one;
      logic [7:0] chan_two;
   } req_type;

   typedef struct packed {
      logic [2:0] entry_index;
      logic [3:0] cleared_count;
      logic       foreground;
      logic       book_full;
   } rsp_type;

   // One codebook entry as it is kept in memory.
   typedef struct packed {
      logic [23:0] learn_high;
      logic [23:0] learn_low;
      logic [23:0] box_max;
      logic [23:0] box_min;
      logic [31:0] last_update;
      logic [31:0] staleness;
   } entry_type;

endpackage

// ===== hw/rtl/cbm_ram.sv =====
// ----------------------------------------------------------------------------
// Codebook background model RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/codebook_background_model.sv =====
// ----------------------------------------------------------------------------
// Codebook background model
// Per-pixel codebook with learn, clear and classify operations.
// ----------------------------------------------------------------------------
// Channel  Handshake      Payload               Direction
// req      valid / stall  cbm_pkg::req_type     in
// rsp      valid / stall  cbm_pkg::rsp_type     out
// csr      valid / ready  index, data           in
//
// Each beat reads the pixel state, then scans the entries in the book in turn.
// A learn that keeps an entry adds an adjust pass, and a classify hit ends the scan early.
// One entry memory port with registered read sets the steps per entry: read, wait, process.
// After reset the pixel state memory is swept, one cycle per pixel address,
// before the first beat is taken. A finished beat waits while a result stalls.
// ----------------------------------------------------------------------------
`include "codebook_background_model_macros.svh"

module codebook_background_model #(
   parameter int NUM_PIXELS  = 1024,
   parameter int MAX_ENTRIES = 8,
   parameter int NUM_CHAN    = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cbm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_data
);

   localparam int PW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = PW + EW;
   localparam int SW = CW + 32;

   localparam logic [3:0] ST_SWEEP  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_PRD    = 4'd2;
   localparam logic [3:0] ST_PWAIT  = 4'd3;
   localparam logic [3:0] ST_ERD    = 4'd4;
   localparam logic [3:0] ST_EWAIT  = 4'd5;
   localparam logic [3:0] ST_EPROC  = 4'd6;
   localparam logic [3:0] ST_FIN    = 4'd7;
   localparam logic [3:0] ST_ADJRD  = 4'd8;
   localparam logic [3:0] ST_ADJW   = 4'd9;
   localparam logic [3:0] ST_ADJP   = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [23:0] bounds_ff, bounds_in, minm_ff, minm_in, maxm_ff, maxm_in;
   cbm_pkg::req_type req_ff, req_in;
   cbm_pkg::rsp_type rsp_ff, rsp_in;
   cbm_pkg::rsp_type res_ff, res_in;
   logic        rspv_ff, rspv_in;
   logic [PW-1:0] px_ff, px_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, k_ff, k_in, m_ff, m_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [31:0]   acc_ff, acc_in;
   logic          found_ff, found_in;
   logic [PW-1:0] sweep_ff, sweep_in;

   logic          pw_en;
   logic [PW-1:0] pw_addr, pr_addr;
   logic [SW-1:0] pw_data, pr_data;
   logic          ew_en;
   logic [AW-1:0] ew_addr, er_addr;
   cbm_pkg::entry_type ew_data, er_data;

   cbm_ram #(.WIDTH(SW), .DEPTH(1 << PW)) u_pix_ram (
      .clock(clock), .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(pr_addr), .rd_data(pr_data)
   );

   cbm_ram #(.WIDTH($bits(cbm_pkg::entry_type)), .DEPTH(1 << AW)) u_entry_ram (
      .clock(clock), .wr_en(ew_en), .wr_addr(ew_addr), .wr_data(ew_data),
      .rd_addr(er_addr), .rd_data(er_data)
   );

   logic [7:0] pch [3];
   assign pch[0] = req_ff.chan_zero;
   assign pch[1] = req_ff.chan_one;
   assign pch[2] = req_ff.chan_two;

   logic [7:0] hi_t [3];
   logic [7:0] lo_t [3];
   logic       learn_ok, class_ok;
   cbm_pkg::entry_type upd, adj;
   logic [31:0] run;

   always_comb begin
      logic [8:0]  s9;
      logic signed [9:0] lo10, hi10, pv;
      learn_ok = 1'b1;
      class_ok = 1'b1;
      upd = er_data;
      adj = er_data;
      for (int n = 0; n < 3; n++) begin
         s9 = {1'b0, pch[n]} + {1'b0, bounds_ff[8*n +: 8]};
         hi_t[n] = (s9 > 9'(cbm_pkg::SAT_MAX)) ? 8'(cbm_pkg::SAT_MAX) : s9[7:0];
         lo_t[n] = (pch[n] > bounds_ff[8*n +: 8]) ? 8'(pch[n] - bounds_ff[8*n +: 8])
                                                  : 8'd0;
      end
      for (int n = 0; n < NUM_CHAN && n < 3; n++) begin
         if (!(er_data.learn_low[8*n +: 8] <= pch[n] &&
               pch[n] <= er_data.learn_high[8*n +: 8])) begin
            learn_ok = 1'b0;
         end
         pv   = signed'({2'b00, pch[n]});
         lo10 = signed'({2'b00, er_data.box_min[8*n +: 8]})
              - 10'(signed'(minm_ff[8*n +: 8]));
         hi10 = signed'({2'b00, er_data.box_max[8*n +: 8]})
              + 10'(signed'(maxm_ff[8*n +: 8]));
         if (!(lo10 <= pv && pv <= hi10)) begin
            class_ok = 1'b0;
         end
         if (er_data.box_max[8*n +: 8] < pch[n]) begin
            upd.box_max[8*n +: 8] = pch[n];
         end else if (er_data.box_min[8*n +: 8] > pch[n]) begin
            upd.box_min[8*n +: 8] = pch[n];
         end
         if (er_data.learn_high[8*n +: 8] < hi_t[n]) begin
            adj.learn_high[8*n +: 8] = er_data.learn_high[8*n +: 8] + 8'd1;
         end
         if (er_data.learn_low[8*n +: 8] > lo_t[n]) begin
            adj.learn_low[8*n +: 8] = er_data.learn_low[8*n +: 8] - 8'd1;
         end
      end
   end

   always_comb begin
      logic hit;
      cbm_pkg::entry_type ne;
      state_in  = state_ff;
      bounds_in = bounds_ff;
      minm_in   = minm_ff;
      maxm_in   = maxm_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      res_in    = res_ff;
      rspv_in   = rspv_ff;
      px_in     = px_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      clr_in    = clr_ff;
      acc_in    = acc_ff;
      found_in  = found_ff;
      sweep_in  = sweep_ff;
      pw_en     = 1'b0;
      pw_addr   = px_ff;
      pw_data   = {cnt_ff, acc_ff};
      pr_addr   = px_ff;
      ew_en     = 1'b0;
      ew_addr   = {px_ff, k_ff[EW-1:0]};
      ew_data   = er_data;
      er_addr   = {px_ff, i_ff[EW-1:0]};
      run       = acc_ff - er_data.last_update;
      hit       = 1'b0;
      ne        = '0;

      if (rspv_ff && !rsp_stall) begin
         rspv_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cbm_pkg::REG_LEARN_BOUNDS: bounds_in = csr_data;
            cbm_pkg::REG_MIN_MODS:     minm_in   = csr_data;
            cbm_pkg::REG_MAX_MODS:     maxm_in   = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_SWEEP: begin
            pw_en   = 1'b1;
            pw_addr = sweep_ff;
            pw_data = '0;
            sweep_in = sweep_ff + PW'(1);
            if (sweep_ff == PW'((1 << PW) - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in   = req_data;
               px_in    = PW'(req_data.pixel_index % NUM_PIXELS);
               state_in = ST_PRD;
            end
         end
         ST_PRD: state_in = ST_PWAIT;
         ST_PWAIT: begin
            cnt_in   = pr_data[SW-1 -: CW];
            acc_in   = pr_data[31:0];
            if (req_ff.operation == cbm_pkg::OP_LEARN) begin
               acc_in = pr_data[31:0] + 32'd1;
            end
            i_in     = '0;
            k_in     = '0;
            clr_in   = '0;
            found_in = 1'b0;
            m_in     = pr_data[SW-1 -: CW];
            if (req_ff.operation == cbm_pkg::OP_CLEAR) begin
               acc_in = {1'b0, pr_data[31:1]};
            end
            state_in = ST_ERD;
         end
         ST_ERD: begin
            if (i_ff >= cnt_ff || req_ff.operation == 2'd3) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_EWAIT;
            end
         end
         ST_EWAIT: state_in = ST_EPROC;
         ST_EPROC: begin
            i_in = i_ff + CW'(1);
            state_in = ST_ERD;
            case (req_ff.operation)
               cbm_pkg::OP_LEARN: begin
                  ne = er_data;
                  if (!found_ff && learn_ok) begin
                     ne = upd;
                     ne.last_update = acc_ff;
                     found_in = 1'b1;
                     m_in = i_ff;
                     run = 32'd0;
                  end
                  if (ne.staleness < run) begin
                     ne.staleness = run;
                  end
                  ew_en   = 1'b1;
                  ew_addr = {px_ff, i_ff[EW-1:0]};
                  ew_data = ne;
               end
               cbm_pkg::OP_CLEAR: begin
                  if (er_data.staleness > acc_ff) begin
                     clr_in = clr_ff + CW'(1);
                  end else begin
                     ne = er_data;
                     ne.last_update = '0;
                     ew_en   = 1'b1;
                     ew_data = ne;
                     k_in    = k_ff + CW'(1);
                  end
               end
               default: begin
                  hit = class_ok;
                  if (hit) begin
                     found_in = 1'b1;
                     state_in = ST_FIN;
                  end
               end
            endcase
         end
         ST_FIN: begin
            res_in = '0;
            state_in = ST_DONE;
            case (req_ff.operation)
               cbm_pkg::OP_LEARN: begin
                  pw_en = 1'b1;
                  if (found_ff) begin
                     pw_data = {cnt_ff, acc_ff};
                     i_in = m_ff;
                     state_in = ST_ADJRD;
                  end else if (cnt_ff >= CW'(MAX_ENTRIES)) begin
                     pw_data = {cnt_ff, acc_ff};
                     res_in.book_full = 1'b1;
                  end else begin
                     pw_data = {cnt_ff + CW'(1), acc_ff};
                     for (int n = 0; n < NUM_CHAN && n < 3; n++) begin
                        ne.learn_high[8*n +: 8] = hi_t[n];
                        ne.learn_low[8*n +: 8]  = lo_t[n];
                        ne.box_max[8*n +: 8]    = pch[n];
                        ne.box_min[8*n +: 8]    = pch[n];
                     end
                     ne.last_update = acc_ff;
                     ew_en   = 1'b1;
                     ew_addr = {px_ff, cnt_ff[EW-1:0]};
                     ew_data = ne;
                     i_in = cnt_ff;
                     m_in = cnt_ff;
                     state_in = ST_ADJRD;
                  end
               end
               cbm_pkg::OP_CLEAR: begin
                  pw_en   = 1'b1;
                  pw_data = {k_ff, pr_data[31:0]};
                  res_in.cleared_count = 4'(clr_ff);
               end
               cbm_pkg::OP_CLASSIFY: res_in.foreground = !found_ff;
               default: ;
            endcase
         end
         ST_ADJRD: state_in = ST_ADJW;
         ST_ADJW: state_in = ST_ADJP;
         ST_ADJP: begin
            ew_en   = 1'b1;
            ew_addr = {px_ff, m_ff[EW-1:0]};
            ew_data = adj;
            res_in.entry_index = 3'(m_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rspv_ff || !rsp_stall) begin
               rsp_in   = res_ff;
               rspv_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         sweep_ff  <= '0;
         rspv_ff   <= 1'b0;
         bounds_ff <= 24'h0A0A0A;
         minm_ff   <= '0;
         maxm_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         rspv_ff   <= rspv_in;
         bounds_ff <= bounds_in;
         minm_ff   <= minm_in;
         maxm_ff   <= maxm_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      res_ff   <= res_in;
      px_ff    <= px_in;
      cnt_ff   <= cnt_in;
      i_ff     <= i_in;
      k_ff     <= k_in;
      m_ff     <= m_in;
      clr_ff   <= clr_in;
      acc_ff   <= acc_in;
      found_ff <= found_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   `CBM_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall,
      "accepted beat did not make the block busy")
   `CBM_ASSERT_IMP(a_sweep_no_rsp, clock, reset, state_ff == ST_SWEEP, !rsp_valid,
      "result shown during memory sweep")
   `CBM_ASSERT_IMP(a_one_field, clock, reset, rsp_valid,
      !(rsp_data.foreground && rsp_data.book_full), "two operations reported at once")
   `CBM_ASSERT_IMP(a_cnt_bound, clock, reset, state_ff == ST_ERD,
      cnt_ff <= CW'(MAX_ENTRIES), "entry count beyond the book size")

endmodule
